// ----- hw/rtl/soe_pkg.sv -----
package soe_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int PRICE_BITS = 32;
  localparam int FULL_SCALE = 100;
  localparam int PERCENT    = 100;

  // window length counts 1..WINDOW_MAX
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int WLEN_W  = 7;
  localparam int GAIN_W  = 17;
  localparam int CFG_W   = 17;
  localparam int OUT_W   = 17;
  localparam int ONE_Q16 = 65536;

  // register indexes on the write port
  localparam logic [0:0] CFG_WINDOW_LENGTH  = 1'b0;
  localparam logic [0:0] CFG_SMOOTHING_GAIN = 1'b1;

  // ratio is signed Q3.16
  localparam int INT_BITS  = 3;
  localparam int FRAC_BITS = 16;
  localparam int QUO_W     = INT_BITS + FRAC_BITS;
  localparam int RATIO_W   = QUO_W + 1;
  localparam int EMA_SHIFT = 4;
  localparam int EMA_W     = RATIO_W + EMA_SHIFT;

  typedef struct packed {
    logic shift;
    logic clear;
    logic step;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/soe_cell.sv -----
module soe_cell (
  input  logic                           clk,
  input  soe_pkg::cell_ctl_t             ctl,
  input  logic                           active,
  input  logic [soe_pkg::PRICE_BITS-1:0] high_in,
  input  logic [soe_pkg::PRICE_BITS-1:0] low_in,
  input  logic [soe_pkg::PRICE_BITS-1:0] min_in,
  input  logic [soe_pkg::PRICE_BITS-1:0] max_in,
  output logic [soe_pkg::PRICE_BITS-1:0] high,
  output logic [soe_pkg::PRICE_BITS-1:0] low,
  output logic [soe_pkg::PRICE_BITS-1:0] part_min,
  output logic [soe_pkg::PRICE_BITS-1:0] part_max
);
  import soe_pkg::*;

  logic [PRICE_BITS-1:0] min_next;
  logic [PRICE_BITS-1:0] max_next;

  always_comb begin
    min_next = '1;
    max_next = '0;
    if (active) begin
      min_next = (low < min_in) ? low : min_in;
      max_next = (high > max_in) ? high : max_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      high <= high_in;
      low  <= low_in;
    end
    // fold the partial from the older neighbor into this entry
    if (ctl.clear) begin
      part_min <= '1;
      part_max <= '0;
    end else if (ctl.step) begin
      part_min <= min_next;
      part_max <= max_next;
    end
  end

endmodule

// ----- hw/rtl/soe_chain.sv -----
module soe_chain (
  input  logic                           clk,
  input  soe_pkg::cell_ctl_t             ctl,
  input  logic [soe_pkg::CNT_W-1:0]      len,
  input  logic [soe_pkg::PRICE_BITS-1:0] new_high,
  input  logic [soe_pkg::PRICE_BITS-1:0] new_low,
  output logic [soe_pkg::PRICE_BITS-1:0] win_min,
  output logic [soe_pkg::PRICE_BITS-1:0] win_max
);
  import soe_pkg::*;

  logic [PRICE_BITS-1:0] high_c [WINDOW_MAX];
  logic [PRICE_BITS-1:0] low_c  [WINDOW_MAX];
  logic [PRICE_BITS-1:0] min_c  [WINDOW_MAX];
  logic [PRICE_BITS-1:0] max_c  [WINDOW_MAX];

  // cell 0 holds the newest candle; partials travel toward cell 0
  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    logic [PRICE_BITS-1:0] h_in;
    logic [PRICE_BITS-1:0] l_in;
    logic [PRICE_BITS-1:0] mn_in;
    logic [PRICE_BITS-1:0] mx_in;

    if (j == 0) begin : g_head
      assign h_in = new_high;
      assign l_in = new_low;
    end else begin : g_body
      assign h_in = high_c[j-1];
      assign l_in = low_c[j-1];
    end

    if (j == WINDOW_MAX - 1) begin : g_tail
      assign mn_in = '1;
      assign mx_in = '0;
    end else begin : g_link
      assign mn_in = min_c[j+1];
      assign mx_in = max_c[j+1];
    end

    soe_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .active   (CNT_W'(j) < len),
      .high_in  (h_in),
      .low_in   (l_in),
      .min_in   (mn_in),
      .max_in   (mx_in),
      .high     (high_c[j]),
      .low      (low_c[j]),
      .part_min (min_c[j]),
      .part_max (max_c[j])
    );
  end

  assign win_min = min_c[0];
  assign win_max = max_c[0];

endmodule

// ----- hw/rtl/soe_div.sv -----
module soe_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [soe_pkg::PRICE_BITS-1:0] dividend,
  input  logic [soe_pkg::PRICE_BITS-1:0] divisor,
  output logic                           done,
  output logic [soe_pkg::QUO_W-1:0]      quotient
);
  import soe_pkg::*;

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic                  busy;
  logic [STEP_W-1:0]     steps;
  logic [PRICE_BITS-1:0] rem;
  logic [QUO_W-1:0]      feed;
  logic [PRICE_BITS-1:0] den;
  logic [PRICE_BITS:0]   trial;
  logic                  take;

  // caller guarantees dividend < divisor << INT_BITS, so QUO_W bits suffice
  assign trial = {rem, feed[QUO_W-1]};
  assign take  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= dividend >> INT_BITS;
        feed  <= {dividend[INT_BITS-1:0], FRAC_BITS'(0)};
        den   <= divisor;
        steps <= STEP_W'(QUO_W);
        busy  <= 1'b1;
      end else if (busy) begin
        if (take) begin
          rem      <= PRICE_BITS'(trial - {1'b0, den});
          quotient <= {quotient[QUO_W-2:0], 1'b1};
        end else begin
          rem      <= trial[PRICE_BITS-1:0];
          quotient <= {quotient[QUO_W-2:0], 1'b0};
        end
        feed  <= feed << 1;
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/stochastic_oscillator_ema.sv -----
// Smoothed stochastic oscillator, one candle per request.
// Candle channel: candle_valid/candle_ready with high_price, low_price,
// close_price and series_start (clears the window and average first).
// Result channel: result_valid/result_ready with oscillator in Q1.16.
// Registers: cfg_write with cfg_index 0 = window_length, 1 = smoothing_gain;
// write them only while the block is idle.
// A candle that leaves the window short of window_length candles gives no
// result; the block is ready again in the next cycle.
// A candle that completes a window passes from acceptance to result_valid
// through min/max folding along the cell row, the bit-serial ratio divider,
// the average update and the scaling to Q1.16. A flat or saturated range
// skips the divider; the first ratio of a series skips the multiply. One
// candle is in work at a time.
// The finished value waits in the output register while result_ready is
// low; a later candle may already be accepted and is held before its own
// result until the register frees up.
// Reset clears the fill count and the average and sets window_length = 14
// and smoothing_gain = 32768.
module stochastic_oscillator_ema (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           candle_valid,
  output logic                           candle_ready,
  input  logic [soe_pkg::PRICE_BITS-1:0] high_price,
  input  logic [soe_pkg::PRICE_BITS-1:0] low_price,
  input  logic [soe_pkg::PRICE_BITS-1:0] close_price,
  input  logic                           series_start,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [soe_pkg::OUT_W-1:0]      oscillator,
  input  logic                           cfg_write,
  input  logic [0:0]                     cfg_index,
  input  logic [soe_pkg::CFG_W-1:0]      cfg_data
);
  import soe_pkg::*;

  localparam logic [RATIO_W-1:0] RATIO_MAX = {1'b0, {(RATIO_W-1){1'b1}}};
  localparam logic [RATIO_W-1:0] RATIO_MIN = {1'b1, {(RATIO_W-1){1'b0}}};

  localparam int PROD_W = EMA_W + 1 + GAIN_W + 1;
  localparam int STEP_W = PROD_W - FRAC_BITS;
  localparam int SUM_W  = STEP_W + 1;

  // output scaling: floor((ema * PERCENT + 8 * FULL_SCALE) / (16 * FULL_SCALE))
  localparam int OUT_DIV  = 16 * FULL_SCALE;
  localparam int OUT_BIAS = 8 * FULL_SCALE;
  localparam int DIV_W    = $clog2(OUT_DIV + 1);
  localparam int OUT_X_W  = EMA_W - 1 + $clog2(PERCENT + 1) + 1;
  localparam int RECIP_SH = OUT_X_W + 1;
  localparam longint unsigned RECIP = (64'd1 << RECIP_SH) / OUT_DIV;
  localparam int RECIP_W  = RECIP_SH - $clog2(OUT_DIV) + 1;
  localparam int QE_W     = OUT_X_W + RECIP_W - RECIP_SH;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_RANGE, S_CHECK, S_DIV, S_DIFF, S_MUL, S_UPD,
    S_SCALE, S_RECIP, S_BACK, S_FIX, S_HOLD
  } state_t;

  state_t state;

  logic [WLEN_W-1:0]      window_length;
  logic [GAIN_W-1:0]      smoothing_gain;
  logic [CNT_W-1:0]       fill_count;
  logic [CNT_W-1:0]       scan_cnt;
  logic                   seed;
  logic [PRICE_BITS-1:0]  close_r;
  logic                   neg;
  logic                   flat;
  logic [PRICE_BITS-1:0]  mag;
  logic [PRICE_BITS-1:0]  den;
  logic signed [RATIO_W-1:0] ratio;
  logic signed [EMA_W-1:0]   ema_value;
  logic signed [EMA_W:0]     diff;
  logic signed [PROD_W-1:0]  prod;
  logic                   pos;
  logic [OUT_X_W-1:0]     x_val;
  logic [QE_W-1:0]        q_est;
  logic [OUT_X_W-1:0]     q_back;
  logic [OUT_W-1:0]       res;

  logic                   accept;
  logic [CNT_W-1:0]       len_eff;
  logic [GAIN_W-1:0]      gain_eff;
  logic [CNT_W-1:0]       fill_base;
  logic [CNT_W-1:0]       fill_next;
  cell_ctl_t              ctl;
  logic [PRICE_BITS-1:0]  win_min;
  logic [PRICE_BITS-1:0]  win_max;
  logic                   div_start;
  logic                   div_done;
  logic [QUO_W-1:0]       div_quo;
  logic                   over;
  logic signed [EMA_W-1:0]   target;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [STEP_W-1:0]  upd_step;
  logic signed [SUM_W-1:0]   upd_sum;
  logic signed [EMA_W-1:0]   ema_clamp;
  logic [OUT_X_W+RECIP_W-1:0] recip_prod;
  logic [QE_W+DIV_W-1:0]  back_prod;
  logic [OUT_X_W-1:0]     rem_out;
  logic [QE_W-1:0]        q_fix;

  assign candle_ready = (state == S_IDLE);
  assign accept       = candle_valid && candle_ready;

  always_comb begin
    if (window_length == '0) begin
      len_eff = CNT_W'(1);
    end else if (window_length > WLEN_W'(WINDOW_MAX)) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = CNT_W'(window_length);
    end

    if (smoothing_gain == '0) begin
      gain_eff = GAIN_W'(1);
    end else if (smoothing_gain > GAIN_W'(ONE_Q16)) begin
      gain_eff = GAIN_W'(ONE_Q16);
    end else begin
      gain_eff = smoothing_gain;
    end

    fill_base = series_start ? '0 : fill_count;
    fill_next = (fill_base == CNT_W'(WINDOW_MAX)) ? fill_base : fill_base + CNT_W'(1);
  end

  always_comb begin
    ctl.shift = accept;
    ctl.clear = accept;
    ctl.step  = (state == S_SCAN);
  end

  soe_chain u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .len      (len_eff),
    .new_high (high_price),
    .new_low  (low_price),
    .win_min  (win_min),
    .win_max  (win_max)
  );

  // ratio reaches 8.0 or more: saturate instead of dividing
  assign over      = {INT_BITS'(0), mag} >= {den, INT_BITS'(0)};
  assign div_start = (state == S_CHECK) && !flat && !over;

  soe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    target     = $signed({ratio, EMA_SHIFT'(0)});
    prod_rnd   = prod + PROD_W'(32768);
    upd_step   = $signed(prod_rnd[PROD_W-1:FRAC_BITS]);
    upd_sum    = SUM_W'(ema_value) + SUM_W'(upd_step);
    if (upd_sum[SUM_W-1] && !(&upd_sum[SUM_W-2:EMA_W-1])) begin
      ema_clamp = $signed({1'b1, {(EMA_W-1){1'b0}}});
    end else if (!upd_sum[SUM_W-1] && (|upd_sum[SUM_W-2:EMA_W-1])) begin
      ema_clamp = $signed({1'b0, {(EMA_W-1){1'b1}}});
    end else begin
      ema_clamp = upd_sum[EMA_W-1:0];
    end
    recip_prod = x_val * RECIP_W'(RECIP);
    back_prod  = q_est * DIV_W'(OUT_DIV);
    rem_out    = x_val - q_back;
    q_fix      = (rem_out >= OUT_X_W'(OUT_DIV)) ? q_est + QE_W'(1) : q_est;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      fill_count     <= '0;
      ema_value      <= '0;
      window_length  <= WLEN_W'(14);
      smoothing_gain <= GAIN_W'(32768);
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_WINDOW_LENGTH:  window_length  <= cfg_data[WLEN_W-1:0];
          CFG_SMOOTHING_GAIN: smoothing_gain <= cfg_data[GAIN_W-1:0];
        endcase
      end

      if (result_ready && (state != S_HOLD)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fill_count <= fill_next;
            close_r    <= close_price;
            seed       <= fill_base < len_eff;
            scan_cnt   <= '0;
            if (series_start) begin
              ema_value <= '0;
            end
            if (fill_next >= len_eff) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + CNT_W'(1);
          if (scan_cnt == len_eff - CNT_W'(1)) begin
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          neg   <= close_r < win_min;
          mag   <= (close_r < win_min) ? win_min - close_r : close_r - win_min;
          den   <= win_max - win_min;
          flat  <= win_max <= win_min;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (flat) begin
            ratio <= (mag == '0) ? '0 : (neg ? RATIO_MIN : RATIO_MAX);
            state <= S_DIFF;
          end else if (over) begin
            ratio <= neg ? RATIO_MIN : RATIO_MAX;
            state <= S_DIFF;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            ratio <= neg ? RATIO_W'(0) - {1'b0, div_quo} : {1'b0, div_quo};
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (seed) begin
            ema_value <= target;
            state     <= S_SCALE;
          end else begin
            diff  <= (EMA_W+1)'(target) - (EMA_W+1)'(ema_value);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= diff * $signed({1'b0, gain_eff});
          state <= S_UPD;
        end
        S_UPD: begin
          ema_value <= ema_clamp;
          state     <= S_SCALE;
        end
        S_SCALE: begin
          pos   <= !ema_value[EMA_W-1] && (|ema_value);
          x_val <= OUT_X_W'(ema_value[EMA_W-2:0]) * OUT_X_W'(PERCENT)
                   + OUT_X_W'(OUT_BIAS);
          state <= S_RECIP;
        end
        S_RECIP: begin
          q_est <= recip_prod[OUT_X_W+RECIP_W-1:RECIP_SH];
          state <= S_BACK;
        end
        S_BACK: begin
          q_back <= back_prod[OUT_X_W-1:0];
          state  <= S_FIX;
        end
        S_FIX: begin
          if (!pos) begin
            res <= '0;
          end else if (q_fix > QE_W'(ONE_Q16)) begin
            res <= OUT_W'(ONE_Q16);
          end else begin
            res <= q_fix[OUT_W-1:0];
          end
          state <= S_HOLD;
        end
        S_HOLD: begin
          // hold until the output register is free
          if (!result_valid || result_ready) begin
            oscillator   <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW_MAX))
    else $error("fill count beyond window depth");

  a_result_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_HOLD)
    else $error("result raised without a finished request");

  a_res_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> (res <= OUT_W'(ONE_Q16)))
    else $error("oscillator value above one");
`endif

endmodule
